@@ sv/lru_block_cache_with_silent_retry_assert.svh @@
// Assertion macros shared by the cache modules.
// No dependencies; each asserting file includes this header.
`ifndef LRU_BLOCK_CACHE_WITH_SILENT_RETRY_ASSERT_SVH
`define LRU_BLOCK_CACHE_WITH_SILENT_RETRY_ASSERT_SVH

// prop holds at every clock edge outside reset
`define LRUBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrubc assertion failed");

// expr is never true outside reset
`define LRUBC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lrubc forbidden condition seen");

`endif

@@ sv/lrubc_pkg.sv @@
// Shared codes, constants and control structs of the block cache.
// No dependencies.
package lrubc_pkg;

  localparam int unsigned TAG_W       = 16;
  localparam int unsigned MAX_RESULTS = 64;

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_PUBLISH = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;
  localparam logic [1:0] MODE_TRIM    = 2'd3;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_STORED = 3'd2;
  localparam logic [2:0] ST_DEFER  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;
  localparam logic [2:0] ST_EVICT  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam logic CFG_BLOCK_COUNT = 1'b0;
  localparam logic CFG_CAPACITY    = 1'b1;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_TOUCH,
    OP_INSERT,
    OP_EVICT
  } slot_op_e;

  typedef struct packed {
    logic             start;
    logic             clear;
    slot_op_e         op;
    logic [TAG_W-1:0] key;
  } slot_cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [TAG_W-1:0] tag;
  } slot_res_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
    logic clr;
  } sil_ctl_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TAG_W-1:0] index;
    logic             last;
  } emit_t;

endpackage

@@ sv/lru_block_cache_with_silent_retry.sv @@
// Block cache tag manager: true-LRU, fully associative, with silent-block retry.
// One item at a time. Every slot operation is a sweep over all SLOTS slots through
// the shared sweep unit in lrubc_slots: a lookup takes one sweep (miss), two (hit)
// or none (rejected), a publish that is stored or refreshed takes two plus one
// sweep per eviction, a deferred or rejected publish takes none, and a trim takes
// one sweep per eviction. After reset and on every clear item the silent marks
// are swept to zero, and no item is accepted until the sweep ends; configuration
// writes are taken at any time. Results leave through an output register.
// Depends on lrubc_pkg, lrubc_slots and lrubc_silent.
`include "lru_block_cache_with_silent_retry_assert.svh"
module lru_block_cache_with_silent_retry #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned BLOCK_SPAN = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] block_index_i,
  input  logic        block_all_zero_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_index_o,
  output logic [6:0]  entry_count_o,
  output logic        last_o
);
  import lrubc_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(BLOCK_SPAN);
  localparam logic [16:0] MAXB17 = 17'((BLOCK_SPAN > 131071) ? 131071 : BLOCK_SPAN);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EMIT,
    S_LOOK_FIND,
    S_LOOK_TOUCH,
    S_PUB_SIL,
    S_PUB_FIND,
    S_PUB_TOUCH,
    S_PUB_EVICT,
    S_PUB_INS_GO,
    S_PUB_INSERT,
    S_TRIM,
    S_TRIM_EVICT
  } state_e;

  state_e           state_q;
  state_e           em_next_q;
  emit_t            em_q;
  logic [16:0]      block_count_q;
  logic [6:0]       capacity_q;
  logic [CW-1:0]    count_q;
  logic [6:0]       n_q;
  logic             clr_emit_q;
  logic             trim3_q;
  logic             zero_q;
  logic [TAG_W-1:0] key_q;
  logic [SW-1:0]    free_q;
  slot_cmd_t        cmd_q;
  logic [SW-1:0]    slot_arg_q;
  logic [SW-1:0]    rank_arg_q;
  sil_ctl_t         sil_ctl_q;
  logic [AW-1:0]    sil_addr_q;
  logic             out_valid_q;
  logic [2:0]       out_status_q;
  logic [15:0]      out_index_q;
  logic [6:0]       out_count_q;
  logic             out_last_q;

  slot_res_t        slot_res;
  logic [SW-1:0]    res_slot;
  logic [SW-1:0]    res_rank;
  logic [SW-1:0]    free_slot;
  logic             sil_rdata;
  logic             sil_rvalid;
  logic             sil_busy;

  logic [16:0]      nb;
  logic [16:0]      nb_m1;
  logic [16:0]      idx17;
  logic [15:0]      look_key;
  logic             pub_bad;
  logic [CW-1:0]    cap_eff;
  logic [CW-1:0]    cnt_inc;
  logic [CW-1:0]    cnt_dec;
  logic [6:0]       trim_lim;
  logic             trim_go;
  logic             evict_more;
  logic             out_free;

  lrubc_slots #(.SLOTS(SLOTS)) u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_q),
    .slot_i      (slot_arg_q),
    .rank_i      (rank_arg_q),
    .res_o       (slot_res),
    .res_slot_o  (res_slot),
    .res_rank_o  (res_rank),
    .free_slot_o (free_slot)
  );

  lrubc_silent #(.BLOCK_SPAN(BLOCK_SPAN)) u_silent (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (sil_ctl_q),
    .addr_i   (sil_addr_q),
    .rdata_o  (sil_rdata),
    .rvalid_o (sil_rvalid),
    .busy_o   (sil_busy)
  );

  always_comb begin
    nb       = (32'(block_count_q) > BLOCK_SPAN) ? MAXB17 : block_count_q;
    nb_m1    = nb - 17'd1;
    idx17    = {1'b0, block_index_i};
    look_key = (idx17 > nb_m1) ? nb_m1[15:0] : block_index_i;
    pub_bad  = (nb == '0) || (idx17 >= nb);
    if (capacity_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity_q) > SLOTS) begin
      cap_eff = CW'(SLOTS);
    end else begin
      cap_eff = CW'(capacity_q);
    end
    cnt_inc    = count_q + CW'(1);
    cnt_dec    = count_q - CW'(1);
    // a trim item keeps room for its closing done item
    trim_lim   = trim3_q ? 7'(MAX_RESULTS - 1) : 7'(MAX_RESULTS);
    trim_go    = (count_q > cap_eff) && (n_q < trim_lim);
    evict_more = (cnt_dec > cap_eff) && ((n_q + 7'd1) < 7'(MAX_RESULTS));
    out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      capacity_q    <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BLOCK_COUNT) begin
        block_count_q <= cfg_wdata_i;
      end else if (cfg_index_i == CFG_CAPACITY) begin
        capacity_q <= cfg_wdata_i[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_emit_q  <= 1'b0;
      count_q     <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      sil_ctl_q   <= '0;
    end else begin
      cmd_q.start <= 1'b0;
      cmd_q.clear <= 1'b0;
      sil_ctl_q   <= '0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLEAR: begin
          if (!sil_busy) begin
            clr_emit_q <= 1'b0;
            if (clr_emit_q) begin
              em_q      <= '{ST_DONE, 16'd0, 1'b1};
              em_next_q <= S_IDLE;
              state_q   <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            n_q     <= '0;
            zero_q  <= block_all_zero_i;
            trim3_q <= 1'b0;
            unique case (mode_i)
              MODE_LOOKUP: begin
                if (nb == '0) begin
                  em_q      <= '{ST_REJECT, 16'd0, 1'b1};
                  em_next_q <= S_IDLE;
                  state_q   <= S_EMIT;
                end else begin
                  key_q   <= look_key;
                  cmd_q   <= '{start: 1'b1, clear: 1'b0, op: OP_FIND, key: look_key};
                  state_q <= S_LOOK_FIND;
                end
              end
              MODE_PUBLISH: begin
                key_q <= block_index_i;
                if (pub_bad) begin
                  em_q      <= '{ST_REJECT, block_index_i, 1'b1};
                  em_next_q <= S_IDLE;
                  state_q   <= S_EMIT;
                end else begin
                  sil_ctl_q.rd <= 1'b1;
                  sil_addr_q   <= AW'(block_index_i);
                  state_q      <= S_PUB_SIL;
                end
              end
              MODE_CLEAR: begin
                cmd_q.clear   <= 1'b1;
                count_q       <= '0;
                sil_ctl_q.clr <= 1'b1;
                clr_emit_q    <= 1'b1;
                state_q       <= S_CLEAR;
              end
              MODE_TRIM: begin
                trim3_q <= 1'b1;
                state_q <= S_TRIM;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= em_q.status;
            out_index_q  <= em_q.index;
            out_count_q  <= 7'(count_q);
            out_last_q   <= em_q.last;
            n_q          <= n_q + 7'd1;
            state_q      <= em_next_q;
          end
        end

        S_LOOK_FIND: begin
          if (slot_res.done) begin
            if (slot_res.found) begin
              cmd_q      <= '{start: 1'b1, clear: 1'b0, op: OP_TOUCH, key: key_q};
              slot_arg_q <= res_slot;
              rank_arg_q <= res_rank;
              state_q    <= S_LOOK_TOUCH;
            end else begin
              em_q      <= '{ST_MISS, key_q, 1'b1};
              em_next_q <= S_IDLE;
              state_q   <= S_EMIT;
            end
          end
        end

        S_LOOK_TOUCH: begin
          if (slot_res.done) begin
            em_q      <= '{ST_HIT, key_q, 1'b1};
            em_next_q <= S_IDLE;
            state_q   <= S_EMIT;
          end
        end

        S_PUB_SIL: begin
          if (sil_rvalid) begin
            if (zero_q && !sil_rdata) begin
              // first sight of an all-zero block: mark it and hold off
              sil_ctl_q.wr    <= 1'b1;
              sil_ctl_q.wdata <= 1'b1;
              em_q            <= '{ST_DEFER, key_q, 1'b1};
              em_next_q       <= S_IDLE;
              state_q         <= S_EMIT;
            end else begin
              if (zero_q) begin
                sil_ctl_q.wr    <= 1'b1;
                sil_ctl_q.wdata <= 1'b0;
              end
              cmd_q   <= '{start: 1'b1, clear: 1'b0, op: OP_FIND, key: key_q};
              state_q <= S_PUB_FIND;
            end
          end
        end

        S_PUB_FIND: begin
          if (slot_res.done) begin
            if (slot_res.found) begin
              cmd_q      <= '{start: 1'b1, clear: 1'b0, op: OP_TOUCH, key: key_q};
              slot_arg_q <= res_slot;
              rank_arg_q <= res_rank;
              state_q    <= S_PUB_TOUCH;
            end else if (count_q >= CW'(SLOTS)) begin
              cmd_q      <= '{start: 1'b1, clear: 1'b0, op: OP_EVICT, key: key_q};
              rank_arg_q <= SW'(SLOTS - 1);
              state_q    <= S_PUB_EVICT;
            end else begin
              free_q  <= free_slot;
              state_q <= S_PUB_INS_GO;
            end
          end
        end

        S_PUB_TOUCH: begin
          if (slot_res.done) begin
            em_q      <= '{ST_STORED, key_q, !(count_q > cap_eff)};
            em_next_q <= S_TRIM;
            state_q   <= S_EMIT;
          end
        end

        S_PUB_EVICT: begin
          if (slot_res.done) begin
            count_q   <= cnt_dec;
            free_q    <= res_slot;
            em_q      <= '{ST_EVICT, slot_res.tag, 1'b0};
            em_next_q <= S_PUB_INS_GO;
            state_q   <= S_EMIT;
          end
        end

        S_PUB_INS_GO: begin
          cmd_q      <= '{start: 1'b1, clear: 1'b0, op: OP_INSERT, key: key_q};
          slot_arg_q <= free_q;
          state_q    <= S_PUB_INSERT;
        end

        S_PUB_INSERT: begin
          if (slot_res.done) begin
            count_q   <= cnt_inc;
            em_q      <= '{ST_STORED, key_q, !(cnt_inc > cap_eff)};
            em_next_q <= S_TRIM;
            state_q   <= S_EMIT;
          end
        end

        S_TRIM: begin
          if (trim_go) begin
            cmd_q      <= '{start: 1'b1, clear: 1'b0, op: OP_EVICT, key: key_q};
            rank_arg_q <= SW'(cnt_dec);
            state_q    <= S_TRIM_EVICT;
          end else if (trim3_q) begin
            em_q      <= '{ST_DONE, 16'd0, 1'b1};
            em_next_q <= S_IDLE;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_TRIM_EVICT: begin
          if (slot_res.done) begin
            if (slot_res.found) begin
              count_q   <= cnt_dec;
              em_q      <= '{ST_EVICT, slot_res.tag, !trim3_q && !evict_more};
              em_next_q <= S_TRIM;
              state_q   <= S_EMIT;
            end else if (trim3_q) begin
              em_q      <= '{ST_DONE, 16'd0, 1'b1};
              em_next_q <= S_IDLE;
              state_q   <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;
  assign entry_count_o  = out_count_q;
  assign last_o         = out_last_q;

  `LRUBC_ASSERT(a_ready_not_clearing, clk_i, rst_ni, in_ready_o |-> !sil_busy)
  `LRUBC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(SLOTS))

endmodule

@@ sv/lrubc_silent.sv @@
// Silent-block marks: one bit per block index in a single-port memory.
// Depends on lrubc_pkg; sweeps the memory to zero after reset and on request.
`include "lru_block_cache_with_silent_retry_assert.svh"
module lrubc_silent #(
  parameter int unsigned BLOCK_SPAN = 65536,
  localparam int unsigned AW = $clog2(BLOCK_SPAN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrubc_pkg::sil_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  output logic              rdata_o,
  output logic              rvalid_o,
  output logic              busy_o
);
  import lrubc_pkg::*;

  logic          mem [BLOCK_SPAN];
  logic          busy_q;
  logic          rvalid_q;
  logic          rdata_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= ctl_i.rd;
      if (ctl_i.clr) begin
        busy_q    <= 1'b1;
        clr_cnt_q <= '0;
      end else if (busy_q) begin
        if (clr_cnt_q == AW'(BLOCK_SPAN - 1)) begin
          busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= 1'b0;
    end else if (ctl_i.wr) begin
      mem[addr_i] <= ctl_i.wdata;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;
  // a clear request counts as busy in the cycle before the sweep starts
  assign busy_o   = busy_q | ctl_i.clr;

  `LRUBC_ASSERT(a_read_not_clearing, clk_i, rst_ni, rvalid_q |-> !busy_q)

endmodule

@@ sv/lrubc_slots.sv @@
// Tag and LRU-rank store with the shared sweep unit that visits one slot a cycle.
// Depends on lrubc_pkg; valid bits in flops, tags and ranks in memory.
`include "lru_block_cache_with_silent_retry_assert.svh"
module lrubc_slots #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrubc_pkg::slot_cmd_t   cmd_i,
  input  logic [SW-1:0]          slot_i,
  input  logic [SW-1:0]          rank_i,
  output lrubc_pkg::slot_res_t   res_o,
  output logic [SW-1:0]          res_slot_o,
  output logic [SW-1:0]          res_rank_o,
  output logic [SW-1:0]          free_slot_o
);
  import lrubc_pkg::*;

  logic [TAG_W-1:0] tag_mem  [SLOTS];
  logic [SW-1:0]    rank_mem [SLOTS];

  logic [SLOTS-1:0] valid_q;
  logic             busy_q;
  logic [SW:0]      cnt_q;
  logic             pv_q;
  logic             done_q;
  logic             found_q;
  logic             free_found_q;

  slot_op_e         op_q;
  logic [TAG_W-1:0] key_q;
  logic [SW-1:0]    slot_q;
  logic [SW-1:0]    rank_q;
  logic [TAG_W-1:0] tag_rd_q;
  logic [SW-1:0]    rank_rd_q;
  logic [SW-1:0]    pi_q;
  logic [SW-1:0]    res_slot_q;
  logic [SW-1:0]    res_rank_q;
  logic [SW-1:0]    free_q;
  logic [TAG_W-1:0] tag_q;

  logic             rd_go;
  logic [SW-1:0]    rd_addr;
  logic             v;
  logic             hit_now;
  logic             free_now;
  logic             wr_en;
  logic [TAG_W-1:0] wr_tag;
  logic [SW-1:0]    wr_rank;
  logic             set_v;
  logic             clr_v;

  assign rd_go   = busy_q && (cnt_q < (SW+1)'(SLOTS));
  assign rd_addr = cnt_q[SW-1:0];
  assign v       = valid_q[pi_q];

  // one slot per cycle: the row read last cycle is updated now
  always_comb begin
    hit_now  = 1'b0;
    free_now = 1'b0;
    wr_en    = 1'b0;
    wr_tag   = tag_rd_q;
    wr_rank  = rank_rd_q;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    if (pv_q) begin
      unique case (op_q)
        OP_FIND: begin
          hit_now  = v && (tag_rd_q == key_q) && !found_q;
          free_now = !v && !free_found_q;
        end
        OP_TOUCH: begin
          if (pi_q == slot_q) begin
            wr_en   = 1'b1;
            wr_rank = '0;
          end else if (v && (rank_rd_q < rank_q)) begin
            wr_en   = 1'b1;
            wr_rank = rank_rd_q + SW'(1);
          end
        end
        OP_INSERT: begin
          if (pi_q == slot_q) begin
            wr_en   = 1'b1;
            wr_tag  = key_q;
            wr_rank = '0;
            set_v   = 1'b1;
          end else if (v) begin
            wr_en   = 1'b1;
            wr_rank = rank_rd_q + SW'(1);
          end
        end
        OP_EVICT: begin
          // ranks stay a permutation, so the oldest entry holds rank count-1
          hit_now = v && (rank_rd_q == rank_q) && !found_q;
          clr_v   = hit_now;
        end
        default: begin
          hit_now = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      pv_q   <= rd_go;
      done_q <= busy_q && (cnt_q == (SW+1)'(SLOTS));
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else begin
        if (set_v) valid_q[pi_q] <= 1'b1;
        if (clr_v) valid_q[pi_q] <= 1'b0;
      end
      if (cmd_i.start) begin
        busy_q       <= 1'b1;
        cnt_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        found_q      <= found_q | hit_now;
        free_found_q <= free_found_q | free_now;
        if (busy_q) begin
          if (rd_go) begin
            cnt_q <= cnt_q + (SW+1)'(1);
          end else begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      key_q  <= cmd_i.key;
      slot_q <= slot_i;
      rank_q <= rank_i;
    end
    if (rd_go) begin
      tag_rd_q  <= tag_mem[rd_addr];
      rank_rd_q <= rank_mem[rd_addr];
      pi_q      <= rd_addr;
    end
    if (wr_en) begin
      tag_mem[pi_q]  <= wr_tag;
      rank_mem[pi_q] <= wr_rank;
    end
    if (hit_now) begin
      res_slot_q <= pi_q;
      res_rank_q <= rank_rd_q;
      tag_q      <= tag_rd_q;
    end
    if (free_now) begin
      free_q <= pi_q;
    end
  end

  assign res_o       = '{done: done_q, found: found_q, tag: tag_q};
  assign res_slot_o  = res_slot_q;
  assign res_rank_o  = res_rank_q;
  assign free_slot_o = free_q;

  `LRUBC_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, cmd_i.start && busy_q)
  `LRUBC_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> !busy_q && !pv_q)
  `LRUBC_ASSERT(a_hit_valid, clk_i, rst_ni, done_q && op_q == OP_FIND && found_q |-> valid_q[res_slot_q])

endmodule
